@@ hdl/kts_pkg.sv @@
package kts_pkg;

  // one input transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  key_slot;
    logic [31:0] key_stamp;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] sample_at;
  } kts_req_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [7:0]  segment;
    logic [16:0] fraction;
  } kts_rsp_t;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic CFG_KEY_COUNT   = 1'b0;
  localparam logic CFG_CLIP_LENGTH = 1'b1;

  localparam logic [16:0] FRAC_ONE    = 17'd65536;
  localparam int          MOD_STEPS   = 32;
  localparam int          DIV_STEPS   = 16;
  localparam int          VEC_COMPS   = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_CLASS,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_SRCH_END,
    ST_RD_A,
    ST_RD_B,
    ST_LAT_B,
    ST_FRAC,
    ST_DIV,
    ST_MUL,
    ST_MADD,
    ST_OUT
  } kts_state_t;

  // read address source
  typedef enum logic [2:0] {
    RS_FIRST,
    RS_LAST,
    RS_MID,
    RS_I0,
    RS_I1
  } kts_rd_sel_t;

  // how the fraction is formed
  typedef enum logic [1:0] {
    FM_ZERO,
    FM_ONE,
    FM_CHECK
  } kts_frac_mode_t;

  typedef struct packed {
    logic        wr;
    logic        load;
    logic        mod_step;
    kts_rd_sel_t rd_sel;
    logic        cap_s0;
    logic        classify;
    logic        srch_upd;
    logic        srch_end;
    logic        cap_a;
    logic        cap_b;
    logic        frac_setup;
    logic        div_step;
    logic        mul;
    logic        madd;
    logic        load_out;
  } kts_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic n_zero;
    logic go_search;
    logic srch_done;
    logic need_div;
    logic div_last;
    logic comp_last;
    logic out_free;
  } kts_status_t;

endpackage

@@ hdl/keyframe_track_sampler.sv @@
// write transaction: no result
// sample transaction: a bit-serial modulo of the query time, then, when needed, a
// binary search whose probes share the single key memory read port, and a
// bit-serial fraction divide, before the result register is loaded
// one transaction at a time; a finished result waits in the output register
// reset clears the controller, output valid and both config registers; keys are undefined
module keyframe_track_sampler #(
  parameter int MAX_KEYS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  kts_pkg::kts_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output kts_pkg::kts_rsp_t rsp,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import kts_pkg::*;

  logic [8:0]  key_count;
  logic [31:0] clip_length;
  kts_cmd_t    cmd;
  kts_status_t st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= '0;
      clip_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_COUNT:   key_count   <= cfg_data[8:0];
        CFG_CLIP_LENGTH: clip_length <= cfg_data;
        default:         clip_length <= clip_length;
      endcase
    end
  end

  kts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  kts_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .key_count   (key_count),
    .clip_length (clip_length),
    .cmd         (cmd),
    .st          (st),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

  // a sample transaction keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.kind == KIND_SAMPLE) |=> req_stall)
    else $error("block not busy after sample");

  // fraction never above one
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.fraction <= FRAC_ONE))
    else $error("fraction above one");

  // empty track gives zero segment and fraction
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && key_count == '0) |-> (rsp.segment == '0 && rsp.fraction == '0))
    else $error("empty track result not zero");

endmodule

@@ hdl/kts_ctrl.sv @@
module kts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_kind,
  output logic                req_stall,
  input  kts_pkg::kts_status_t st,
  output kts_pkg::kts_cmd_t   cmd
);
  import kts_pkg::*;

  kts_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid && req_kind == KIND_SAMPLE) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (st.mod_last) state_next = ST_RD_FIRST;
      end
      ST_RD_FIRST:  state_next = st.n_zero ? ST_OUT : ST_RD_LAST;
      ST_RD_LAST:   state_next = ST_CLASS;
      ST_CLASS:     state_next = st.go_search ? ST_SRCH_ADDR : ST_RD_A;
      ST_SRCH_ADDR: state_next = st.srch_done ? ST_SRCH_END : ST_SRCH_CMP;
      ST_SRCH_CMP:  state_next = ST_SRCH_ADDR;
      ST_SRCH_END:  state_next = ST_RD_A;
      ST_RD_A:      state_next = ST_RD_B;
      ST_RD_B:      state_next = ST_LAT_B;
      ST_LAT_B:     state_next = ST_FRAC;
      ST_FRAC:      state_next = st.need_div ? ST_DIV : ST_MUL;
      ST_DIV: begin
        if (st.div_last) state_next = ST_MUL;
      end
      ST_MUL:       state_next = ST_MADD;
      ST_MADD:      state_next = st.comp_last ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RS_FIRST;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.wr    = req_valid && (req_kind == KIND_WRITE);
        cmd.load  = req_valid && (req_kind == KIND_SAMPLE);
      end
      ST_MOD:       cmd.mod_step = 1'b1;
      ST_RD_FIRST:  cmd.rd_sel = RS_FIRST;
      ST_RD_LAST: begin
        cmd.rd_sel = RS_LAST;
        cmd.cap_s0 = 1'b1;
      end
      ST_CLASS:     cmd.classify = 1'b1;
      ST_SRCH_ADDR: cmd.rd_sel = RS_MID;
      ST_SRCH_CMP: begin
        cmd.rd_sel   = RS_MID;
        cmd.srch_upd = 1'b1;
      end
      ST_SRCH_END:  cmd.srch_end = 1'b1;
      ST_RD_A:      cmd.rd_sel = RS_I0;
      ST_RD_B: begin
        cmd.rd_sel = RS_I1;
        cmd.cap_a  = 1'b1;
      end
      ST_LAT_B:     cmd.cap_b = 1'b1;
      ST_FRAC:      cmd.frac_setup = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_MUL:       cmd.mul = 1'b1;
      ST_MADD:      cmd.madd = 1'b1;
      ST_OUT:       cmd.load_out = st.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

@@ hdl/kts_dp.sv @@
module kts_dp #(
  parameter int MAX_KEYS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kts_pkg::kts_req_t    req,
  input  logic [8:0]           key_count,
  input  logic [31:0]          clip_length,
  input  kts_pkg::kts_cmd_t    cmd,
  output kts_pkg::kts_status_t st,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output kts_pkg::kts_rsp_t    rsp
);
  import kts_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);

  // key memory: stamp, x, y, z
  logic [127:0] mem [MAX_KEYS];
  logic [127:0] rd_q;
  logic [AW-1:0] rd_addr;

  logic [NW-1:0] n;
  logic [NW-1:0] lo, len, mid, lo_c;
  logic [NW-1:0] seg;
  logic [AW-1:0] i0, i1;
  kts_frac_mode_t mode;

  logic [31:0] dvd, rem, t, s0, sa, sb;
  logic [32:0] mod_r2, div_r2;
  logic [31:0] mod_rem_next;
  logic [31:0] den;
  logic [4:0]  cnt;
  logic [1:0]  comp;
  logic [16:0] frac;
  logic [2:0][31:0] a_vec, b_vec, o_vec;
  logic signed [32:0] diff;
  logic signed [50:0] prod, prod_c, prod_sh;
  logic [31:0] rd_stamp;

  assign n = (32'(key_count) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
  assign rd_stamp = rd_q[127:96];
  assign mid = lo + (len >> 1);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RS_FIRST: rd_addr = '0;
      RS_LAST:  rd_addr = AW'(n - NW'(1));
      RS_MID:   rd_addr = mid[AW-1:0];
      RS_I0:    rd_addr = i0;
      RS_I1:    rd_addr = i1;
      default:  rd_addr = '0;
    endcase
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(req.key_slot) < 32'(n))) begin
      mem[AW'(req.key_slot)] <= {req.key_stamp, req.key_x, req.key_y, req.key_z};
    end
    rd_q <= mem[rd_addr];
  end

  // one bit of restoring division per step, modulo and fraction
  assign mod_r2       = {rem, dvd[31]};
  assign mod_rem_next = (mod_r2 >= {1'b0, clip_length}) ? 32'(mod_r2 - {1'b0, clip_length})
                                                        : mod_r2[31:0];
  assign den    = sb - sa;
  assign div_r2 = {rem, 1'b0};

  // clamp of the search result to 1..n-1
  always_comb begin
    lo_c = (lo == '0) ? NW'(1) : lo;
    if (lo_c >= n) lo_c = n - NW'(1);
  end

  // interpolation arithmetic
  assign diff    = 33'($signed(b_vec[comp])) - 33'($signed(a_vec[comp]));
  assign prod_c  = 51'(diff * $signed({1'b0, frac}));
  assign prod_sh = prod >>> 16;

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd <= req.sample_at;
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.mod_step) begin
      rem <= mod_rem_next;
      dvd <= {dvd[30:0], 1'b0};
      cnt <= cnt + 5'd1;
      if (cnt == 5'(MOD_STEPS - 1)) begin
        t <= (clip_length == '0) ? '0 : mod_rem_next;
      end
    end
    if (cmd.cap_s0) s0 <= rd_stamp;
    if (cmd.classify) begin
      lo   <= '0;
      len  <= n;
      mode <= FM_CHECK;
      if (n == NW'(1) || t <= s0) begin
        seg  <= '0;
        i0   <= '0;
        i1   <= '0;
        mode <= FM_ZERO;
      end else if (t >= rd_stamp) begin
        seg  <= n - NW'(2);
        i0   <= AW'(n - NW'(2));
        i1   <= AW'(n - NW'(1));
        mode <= FM_ONE;
      end
    end
    if (cmd.srch_upd) begin
      if (!(t < rd_stamp)) begin
        lo  <= mid + NW'(1);
        len <= len - (len >> 1) - NW'(1);
      end else begin
        len <= len >> 1;
      end
    end
    if (cmd.srch_end) begin
      seg <= lo_c - NW'(1);
      i0  <= AW'(lo_c - NW'(1));
      i1  <= AW'(lo_c);
    end
    if (cmd.cap_a) begin
      sa    <= rd_q[127:96];
      a_vec <= rd_q[95:0];
    end
    if (cmd.cap_b) begin
      sb    <= rd_q[127:96];
      b_vec <= rd_q[95:0];
    end
    if (cmd.frac_setup) begin
      cnt  <= '0;
      comp <= '0;
      rem  <= t - sa;
      case (mode)
        FM_ZERO: frac <= '0;
        FM_ONE:  frac <= FRAC_ONE;
        default: frac <= (t <= sa) ? 17'd0 : ((t >= sb) ? FRAC_ONE : 17'd0);
      endcase
    end
    if (cmd.div_step) begin
      cnt <= cnt + 5'd1;
      if (div_r2 >= {1'b0, den}) begin
        rem  <= 32'(div_r2 - {1'b0, den});
        frac <= {frac[15:0], 1'b1};
      end else begin
        rem  <= div_r2[31:0];
        frac <= {frac[15:0], 1'b0};
      end
    end
    if (cmd.mul) prod <= prod_c;
    if (cmd.madd) begin
      // quotient by 65536 truncated toward zero
      if (prod[50] && (prod[15:0] != '0)) begin
        o_vec[comp] <= a_vec[comp] + 32'(prod_sh + 51'sd1);
      end else begin
        o_vec[comp] <= a_vec[comp] + 32'(prod_sh);
      end
      comp <= comp + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (n == '0) begin
        rsp <= '0;
      end else begin
        rsp.out_x    <= o_vec[2];
        rsp.out_y    <= o_vec[1];
        rsp.out_z    <= o_vec[0];
        rsp.segment  <= 8'(seg);
        rsp.fraction <= frac;
      end
    end
  end

  // status to controller
  always_comb begin
    st.mod_last  = (cnt == 5'(MOD_STEPS - 1));
    st.n_zero    = (n == '0);
    st.go_search = !(n == NW'(1) || t <= s0) && !(t >= rd_stamp);
    st.srch_done = (len == '0);
    st.need_div  = (mode == FM_CHECK) && (t > sa) && (t < sb);
    st.div_last  = (cnt == 5'(DIV_STEPS - 1));
    st.comp_last = (comp == 2'(VEC_COMPS - 1));
    st.out_free  = !rsp_valid || !rsp_stall;
  end

endmodule
